@@ rtl/mtsg_pkg.sv @@
package mtsg_pkg;

    localparam int MAX_COMPONENTS = 16;
    localparam int SINE_ENTRIES   = 1024;

    localparam int IDX_W      = $clog2(MAX_COMPONENTS);
    localparam int COUNT_W    = 5;
    localparam int SLOT_W     = 4;
    localparam int PHASE_W    = 32;
    localparam int AMP_W      = 16;
    localparam int SAMPLE_W   = 16;
    localparam int INDEX_W    = 24;
    localparam int ENV_W      = 17;
    localparam int GAIN_W     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // sine lookup geometry: quadrant in the top two bits of the table index
    localparam int K_W       = $clog2(SINE_ENTRIES);
    localparam int ROM_DEPTH = SINE_ENTRIES / 4;
    localparam int LOW_W     = K_W - 2;
    localparam int M_W       = K_W - 1;
    localparam int QS_W      = 15;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [ENV_W-1:0] ENV_ONE = ENV_W'(65536);

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_SAMPLES    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_SAMPLES    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_INCREMENT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_DECREMENT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NORM_GAIN       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPONENT_COUNT = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_MAG,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ROUND,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             write;
        logic             clr_acc;
        logic             issue;
        logic [IDX_W-1:0] idx;
        logic             mag;
        logic             mul_lo;
        logic             mul_hi;
        logic             round;
        logic             load_out;
        logic             invalid;
    } t_dp_cmd;

    typedef struct packed {
        logic             count_zero;
        logic [IDX_W-1:0] last_idx;
        logic             pipe_busy;
    } t_dp_sts;

    // Quarter-wave sine at table step m (0 .. ROM_DEPTH), Q0.15 magnitude.
    // Only ever called with constant arguments to build the lookup table and QS_PEAK.
    function automatic logic [QS_W-1:0] qsine(input int unsigned m);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        t;
        logic [63:0]        v;
        logic signed [63:0] sum;
        x   = (64'(m) * 64'd4 * HALF_PI_Q30 + 64'(SINE_ENTRIES / 2)) / 64'(SINE_ENTRIES);
        x2  = (x * x) >> 30;
        t   = x;
        sum = $signed(x);
        t   = ((t * x2) >> 30) / 64'd6;
        sum = sum - $signed(t);
        t   = ((t * x2) >> 30) / 64'd20;
        sum = sum + $signed(t);
        t   = ((t * x2) >> 30) / 64'd42;
        sum = sum - $signed(t);
        t   = ((t * x2) >> 30) / 64'd72;
        sum = sum + $signed(t);
        t   = ((t * x2) >> 30) / 64'd110;
        sum = sum - $signed(t);
        t   = ((t * x2) >> 30) / 64'd156;
        sum = sum + $signed(t);
        if (sum < 0) begin
            sum = 64'sd0;
        end
        v = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[QS_W-1:0];
    endfunction

    localparam logic [QS_W-1:0] QS_PEAK = qsine(ROM_DEPTH);

endpackage

@@ rtl/mtsg_if.sv @@
interface mtsg_req_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [mtsg_pkg::SLOT_W-1:0]  slot;
    logic [mtsg_pkg::PHASE_W-1:0] phase_step;
    logic [mtsg_pkg::PHASE_W-1:0] phase_offset;
    logic [mtsg_pkg::AMP_W-1:0]   amplitude;

    modport source (
        output valid, kind, slot, phase_step, phase_offset, amplitude,
        input  ready
    );
    modport sink (
        input  valid, kind, slot, phase_step, phase_offset, amplitude,
        output ready
    );
endinterface

interface mtsg_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mtsg_pkg::SAMPLE_W-1:0] sample;
    logic                                 last;
    logic                                 invalid;

    modport source (
        output valid, sample, last, invalid,
        input  ready
    );
    modport sink (
        input  valid, sample, last, invalid,
        output ready
    );
endinterface

@@ rtl/mtsg_dp.sv @@
module mtsg_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [mtsg_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [mtsg_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic [mtsg_pkg::SLOT_W-1:0]          i_slot,
    input  logic [mtsg_pkg::PHASE_W-1:0]         i_phase_step,
    input  logic [mtsg_pkg::PHASE_W-1:0]         i_phase_offset,
    input  logic [mtsg_pkg::AMP_W-1:0]           i_amplitude,
    input  mtsg_pkg::t_dp_cmd                    i_cmd,
    output mtsg_pkg::t_dp_sts                    o_sts,
    output logic signed [mtsg_pkg::SAMPLE_W-1:0] o_sample,
    output logic                                 o_last,
    output logic                                 o_invalid
);

    localparam int PROD_W = 34;
    localparam int ACC_W  = 37;
    localparam int MAG_W  = 36;
    localparam int HALF_W = 18;
    localparam int PP_W   = HALF_W + mtsg_pkg::GAIN_W;
    localparam int SUM_W  = PP_W + HALF_W + 1;

    // configuration
    logic [mtsg_pkg::INDEX_W-1:0] r_sample_count;
    logic [mtsg_pkg::INDEX_W-1:0] r_rise_samples;
    logic [mtsg_pkg::INDEX_W-1:0] r_fall_samples;
    logic [mtsg_pkg::ENV_W-1:0]   r_rise_inc;
    logic [mtsg_pkg::ENV_W-1:0]   r_fall_dec;
    logic [mtsg_pkg::GAIN_W-1:0]  r_norm_gain;
    logic [mtsg_pkg::COUNT_W-1:0] r_comp_count;

    // burst state
    logic [mtsg_pkg::INDEX_W-1:0] r_sample_index;
    logic [mtsg_pkg::ENV_W-1:0]   r_envelope;

    // component table
    logic [mtsg_pkg::PHASE_W-1:0] r_steps   [mtsg_pkg::MAX_COMPONENTS];
    logic [mtsg_pkg::PHASE_W-1:0] r_offsets [mtsg_pkg::MAX_COMPONENTS];
    logic [mtsg_pkg::AMP_W-1:0]   r_amps    [mtsg_pkg::MAX_COMPONENTS];

    // pipeline
    logic                          r_v1, r_v2, r_v3, r_v4;
    logic [mtsg_pkg::PHASE_W-1:0]  r_s1_prod;
    logic [mtsg_pkg::PHASE_W-1:0]  r_s1_off;
    logic [mtsg_pkg::AMP_W-1:0]    r_s1_amp;
    logic [mtsg_pkg::M_W-1:0]      r_s2_m;
    logic                          r_s2_neg;
    logic [mtsg_pkg::ENV_W-1:0]    r_s2_w;
    logic signed [mtsg_pkg::SAMPLE_W-1:0] r_s3_sine;
    logic [mtsg_pkg::ENV_W-1:0]    r_s3_w;
    logic signed [PROD_W-1:0]      r_s4_prod;
    logic signed [ACC_W-1:0]       r_acc;

    // scaling
    logic                          r_neg;
    logic [MAG_W-1:0]              r_mag;
    logic [PP_W-1:0]               r_plo;
    logic [PP_W-1:0]               r_phi;
    logic signed [mtsg_pkg::SAMPLE_W-1:0] r_result;

    // output payload
    logic signed [mtsg_pkg::SAMPLE_W-1:0] r_out_sample;
    logic                          r_out_last;
    logic                          r_out_invalid;

    logic [mtsg_pkg::QS_W-1:0]     sine_rom [mtsg_pkg::ROM_DEPTH];

    for (genvar g = 0; g < mtsg_pkg::ROM_DEPTH; g++) begin : g_rom
        assign sine_rom[g] = mtsg_pkg::qsine(g);
    end

    logic [mtsg_pkg::IDX_W-1:0]    wr_idx;
    logic [mtsg_pkg::PHASE_W-1:0]  phase;
    logic [mtsg_pkg::K_W-1:0]      k;
    logic [mtsg_pkg::LOW_W-1:0]    k_low;
    logic [mtsg_pkg::M_W-1:0]      m;
    logic [32:0]                   amp_env;
    logic [mtsg_pkg::QS_W-1:0]     qs;
    logic signed [mtsg_pkg::SAMPLE_W-1:0] sine_val;
    logic [HALF_W-1:0]             mul_a;
    logic [PP_W-1:0]               mul_p;
    logic [SUM_W-1:0]              round_sum;
    logic [SUM_W-32:0]             scaled;
    logic signed [mtsg_pkg::SAMPLE_W-1:0] sat_val;
    logic [mtsg_pkg::INDEX_W-1:0]  total;
    logic [mtsg_pkg::INDEX_W-1:0]  fall_start;
    logic [mtsg_pkg::ENV_W:0]      env_sum;
    logic [mtsg_pkg::ENV_W-1:0]    env_next;
    logic                          is_last;

    assign wr_idx = mtsg_pkg::IDX_W'(i_slot);

    // phase to quarter-wave table step
    always_comb begin
        phase = r_s1_off + r_s1_prod;
        k     = phase[mtsg_pkg::PHASE_W-1 -: mtsg_pkg::K_W];
        k_low = k[mtsg_pkg::LOW_W-1:0];
        if (k[mtsg_pkg::K_W-2]) begin
            m = mtsg_pkg::M_W'(mtsg_pkg::ROM_DEPTH) - {1'b0, k_low};
        end else begin
            m = {1'b0, k_low};
        end
        amp_env = 33'(r_s1_amp) * 33'(r_envelope);
    end

    always_comb begin
        if (r_s2_m[mtsg_pkg::M_W-1]) begin
            qs = mtsg_pkg::QS_PEAK;
        end else begin
            qs = sine_rom[r_s2_m[mtsg_pkg::LOW_W-1:0]];
        end
        if (r_s2_neg) begin
            sine_val = -$signed({1'b0, qs});
        end else begin
            sine_val = $signed({1'b0, qs});
        end
    end

    // magnitude times gain in two halves through one multiplier, then round and saturate
    always_comb begin
        mul_a     = i_cmd.mul_hi ? r_mag[MAG_W-1:HALF_W] : r_mag[HALF_W-1:0];
        mul_p     = PP_W'(mul_a) * PP_W'(r_norm_gain);
        round_sum = (SUM_W'(r_phi) << HALF_W) + SUM_W'(r_plo) + (SUM_W'(1) << 30);
        scaled    = round_sum[SUM_W-1:31];
        if (r_neg) begin
            if (scaled > (SUM_W-31)'(32768)) begin
                sat_val = -16'sd32768;
            end else begin
                sat_val = -$signed(scaled[mtsg_pkg::SAMPLE_W-1:0]);
            end
        end else begin
            if (scaled > (SUM_W-31)'(32767)) begin
                sat_val = 16'sd32767;
            end else begin
                sat_val = $signed(scaled[mtsg_pkg::SAMPLE_W-1:0]);
            end
        end
    end

    // envelope and index advance
    always_comb begin
        total      = (r_sample_count == '0) ? mtsg_pkg::INDEX_W'(1) : r_sample_count;
        fall_start = (r_fall_samples > total) ? '0 : total - r_fall_samples;
        env_sum    = {1'b0, r_envelope} + {1'b0, r_rise_inc};
        if (r_sample_index < r_rise_samples) begin
            if (env_sum > {1'b0, mtsg_pkg::ENV_ONE}) begin
                env_next = mtsg_pkg::ENV_ONE;
            end else begin
                env_next = env_sum[mtsg_pkg::ENV_W-1:0];
            end
        end else if (r_sample_index > fall_start) begin
            env_next = (r_envelope > r_fall_dec) ? r_envelope - r_fall_dec : '0;
        end else begin
            env_next = mtsg_pkg::ENV_ONE;
        end
        is_last = ({1'b0, r_sample_index} + 25'd1) >= {1'b0, total};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= mtsg_pkg::INDEX_W'(1);
            r_rise_samples <= '0;
            r_fall_samples <= '0;
            r_rise_inc     <= '0;
            r_fall_dec     <= '0;
            r_norm_gain    <= mtsg_pkg::GAIN_W'(65536);
            r_comp_count   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mtsg_pkg::CFG_SAMPLE_COUNT:    r_sample_count <= i_cfg_wdata;
                mtsg_pkg::CFG_RISE_SAMPLES:    r_rise_samples <= i_cfg_wdata;
                mtsg_pkg::CFG_FALL_SAMPLES:    r_fall_samples <= i_cfg_wdata;
                mtsg_pkg::CFG_RISE_INCREMENT:  r_rise_inc <= i_cfg_wdata[mtsg_pkg::ENV_W-1:0];
                mtsg_pkg::CFG_FALL_DECREMENT:  r_fall_dec <= i_cfg_wdata[mtsg_pkg::ENV_W-1:0];
                mtsg_pkg::CFG_NORM_GAIN:       r_norm_gain <= i_cfg_wdata;
                mtsg_pkg::CFG_COMPONENT_COUNT: begin
                    r_comp_count <= i_cfg_wdata[mtsg_pkg::COUNT_W-1:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write && (32'(i_slot) < mtsg_pkg::MAX_COMPONENTS)) begin
            r_steps[wr_idx]   <= i_phase_step;
            r_offsets[wr_idx] <= i_phase_offset;
            r_amps[wr_idx]    <= i_amplitude;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_prod <= 32'(r_steps[i_cmd.idx] * r_sample_index);
        r_s1_off  <= r_offsets[i_cmd.idx];
        r_s1_amp  <= r_amps[i_cmd.idx];
        r_s2_m    <= m;
        r_s2_neg  <= k[mtsg_pkg::K_W-1];
        r_s2_w    <= amp_env[32:16];
        r_s3_sine <= sine_val;
        r_s3_w    <= r_s2_w;
        r_s4_prod <= $signed({1'b0, r_s3_w}) * r_s3_sine;
        if (i_cmd.clr_acc) begin
            r_acc <= '0;
        end else if (r_v4) begin
            r_acc <= r_acc + ACC_W'(r_s4_prod);
        end
        if (i_cmd.mag) begin
            r_neg <= r_acc[ACC_W-1];
            r_mag <= r_acc[ACC_W-1] ? MAG_W'(-r_acc) : MAG_W'(r_acc);
        end
        if (i_cmd.mul_lo) begin
            r_plo <= mul_p;
        end
        if (i_cmd.mul_hi) begin
            r_phi <= mul_p;
        end
        if (i_cmd.round) begin
            r_result <= sat_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_index <= '0;
            r_envelope     <= '0;
        end else if (i_cmd.load_out && !i_cmd.invalid) begin
            if (is_last) begin
                r_sample_index <= '0;
                r_envelope     <= '0;
            end else begin
                r_sample_index <= r_sample_index + mtsg_pkg::INDEX_W'(1);
                r_envelope     <= env_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (i_cmd.invalid) begin
                r_out_sample  <= '0;
                r_out_last    <= 1'b0;
                r_out_invalid <= 1'b1;
            end else begin
                r_out_sample  <= r_result;
                r_out_last    <= is_last;
                r_out_invalid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.count_zero = (r_comp_count == '0);
        if (32'(r_comp_count) > mtsg_pkg::MAX_COMPONENTS) begin
            o_sts.last_idx = mtsg_pkg::IDX_W'(mtsg_pkg::MAX_COMPONENTS - 1);
        end else begin
            o_sts.last_idx = mtsg_pkg::IDX_W'(r_comp_count - mtsg_pkg::COUNT_W'(1));
        end
        o_sts.pipe_busy = r_v1 | r_v2 | r_v3 | r_v4;
    end

    assign o_sample  = r_out_sample;
    assign o_last    = r_out_last;
    assign o_invalid = r_out_invalid;

endmodule

@@ rtl/mtsg_ctrl.sv @@
module mtsg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_kind,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  mtsg_pkg::t_dp_sts i_sts,
    output mtsg_pkg::t_dp_cmd o_cmd
);

    mtsg_pkg::t_state           r_state, n_state;
    logic [mtsg_pkg::IDX_W-1:0] r_idx, n_idx;
    logic                       r_invalid, n_invalid;
    logic                       r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mtsg_pkg::ST_IDLE;
            r_idx       <= '0;
            r_invalid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_invalid   <= n_invalid;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_invalid  = r_invalid;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            mtsg_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_kind == mtsg_pkg::KIND_WRITE) begin
                        o_cmd.write = 1'b1;
                    end else if (i_sts.count_zero) begin
                        n_invalid = 1'b1;
                        n_state   = mtsg_pkg::ST_DONE;
                    end else begin
                        n_invalid     = 1'b0;
                        o_cmd.clr_acc = 1'b1;
                        n_idx         = '0;
                        n_state       = mtsg_pkg::ST_ISSUE;
                    end
                end
            end
            mtsg_pkg::ST_ISSUE: begin
                o_cmd.issue = 1'b1;
                o_cmd.idx   = r_idx;
                if (r_idx == i_sts.last_idx) begin
                    n_state = mtsg_pkg::ST_DRAIN;
                end else begin
                    n_idx = r_idx + mtsg_pkg::IDX_W'(1);
                end
            end
            mtsg_pkg::ST_DRAIN: begin
                // wait for the last product to land in the accumulator
                if (!i_sts.pipe_busy) begin
                    n_state = mtsg_pkg::ST_MAG;
                end
            end
            mtsg_pkg::ST_MAG: begin
                o_cmd.mag = 1'b1;
                n_state   = mtsg_pkg::ST_MUL_LO;
            end
            mtsg_pkg::ST_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = mtsg_pkg::ST_MUL_HI;
            end
            mtsg_pkg::ST_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = mtsg_pkg::ST_ROUND;
            end
            mtsg_pkg::ST_ROUND: begin
                o_cmd.round = 1'b1;
                n_state     = mtsg_pkg::ST_DONE;
            end
            mtsg_pkg::ST_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.invalid  = r_invalid;
                    n_state        = mtsg_pkg::ST_IDLE;
                end
            end
            default: n_state = mtsg_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten before its beat was taken");

    a_issue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.issue |-> (o_cmd.idx <= i_sts.last_idx))
        else $error("component issued past the active count");

    a_mag_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mtsg_pkg::ST_MAG) |-> !i_sts.pipe_busy)
        else $error("accumulator read while products still in flight");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !i_sts.pipe_busy)
        else $error("new beat taken while component pipeline busy");

endmodule

@@ rtl/multitone_sine_generator_envelope_top.sv @@
// Multitone sine generator with envelope.
// i_req carries two kinds of beat. kind 0 writes one component (phase step,
// phase offset, amplitude) into table slot `slot` and gives no result.
// kind 1 asks for the next sample of the burst and gives exactly one beat
// on o_rsp: the sample, a last flag on the final sample of the burst, and
// an invalid flag (sample 0) when component_count is zero.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_wdata;
// the user must write it only while the block is idle, which the block
// itself does not enforce. Each write takes effect at the next clock edge.
// A sample request walks the active components one per cycle through a
// phase/sine/product pipeline into an accumulator, then the sum is scaled
// by norm_gain in two halves on one multiplier, rounded and saturated.
// A new request is taken only when the previous one has reached the
// output register. The output register lets the next request start while
// a result waits; when o_rsp stalls, a finished result holds in the
// datapath until the register frees. Synchronous reset clears the burst
// position, envelope, configuration (to its reset values) and all
// handshake state; the component table is not cleared and must be written
// before use.
module multitone_sine_generator_envelope_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mtsg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mtsg_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    mtsg_req_if.sink                        i_req,
    mtsg_rsp_if.source                      o_rsp
);

    mtsg_pkg::t_dp_cmd cmd;
    mtsg_pkg::t_dp_sts sts;

    mtsg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_in_kind   (i_req.kind),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mtsg_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_slot         (i_req.slot),
        .i_phase_step   (i_req.phase_step),
        .i_phase_offset (i_req.phase_offset),
        .i_amplitude    (i_req.amplitude),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_sample       (o_rsp.sample),
        .o_last         (o_rsp.last),
        .o_invalid      (o_rsp.invalid)
    );

endmodule
